// ===== sv/lbfd_pkg.sv =====
// Shared types and command codes for the bit-plane framebuffer draw engine.
`default_nettype none
package lbfd_pkg;

  localparam logic [1:0] REQ_SET_PIXEL  = 2'd0;
  localparam logic [1:0] REQ_READ_PIXEL = 2'd1;
  localparam logic [1:0] REQ_FILL_RECT  = 2'd2;
  localparam logic [1:0] REQ_PATTERN    = 2'd3;

  localparam int unsigned PatternSide = 8;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  x_start;
    logic [4:0]  y_start;
    logic [5:0]  x_end;
    logic [5:0]  y_end;
    logic [63:0] pattern_bits;
    logic [3:0]  pattern_height;
    logic [3:0]  pattern_width;
    logic [7:0]  pen_red;
    logic [7:0]  pen_green;
    logic [7:0]  pen_blue;
    logic        overwrite_black;
  } req_t;

  typedef struct packed {
    logic [7:0] read_red;
    logic [7:0] read_green;
    logic [7:0] read_blue;
    logic       is_read_reply;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic clear_en;
    logic walk_en;
    logic read_en;
    logic rsp_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;
    logic walk_last;
    logic walk_empty;
  } sts_t;

endpackage
`default_nettype wire

// ===== sv/lbfd_ctrl.sv =====
// Controller state machine: clearing pass, command walk, read and reply handoff.
`default_nettype none
module lbfd_ctrl (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  wire            in_is_read_i,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output lbfd_pkg::cmd_t cmd_o,
  input  lbfd_pkg::sts_t sts_i
);
  import lbfd_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_READ,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = accept;
    cmd_o.clear_en = (state_q == ST_CLEAR);
    cmd_o.walk_en  = (state_q == ST_WALK);
    cmd_o.read_en  = (state_q == ST_READ);
    cmd_o.rsp_load = (state_q == ST_DONE) && slot_free;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = in_is_read_i ? ST_READ : ST_WALK;
        end
      end
      ST_WALK: begin
        if (sts_i.walk_empty || sts_i.walk_last) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold the reply until the output register frees up
        if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== sv/lbfd_datapath.sv =====
// Datapath: command registers, walk counters, pixel store and reply register.
`default_nettype none
module lbfd_datapath #(
  parameter int unsigned PANEL_WIDTH  = 32,
  parameter int unsigned HALF_HEIGHT  = 16,
  parameter int unsigned COLOR_PLANES = 2
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  lbfd_pkg::req_t req_i,
  input  lbfd_pkg::cmd_t cmd_i,
  output lbfd_pkg::sts_t sts_o,
  output lbfd_pkg::rsp_t rsp_o
);
  import lbfd_pkg::*;

  localparam int unsigned PanelHeight = 2 * HALF_HEIGHT;
  localparam int unsigned Depth       = PanelHeight * PANEL_WIDTH;
  localparam int unsigned AddrW       = $clog2(Depth);
  localparam int unsigned WordW       = 3 * COLOR_PLANES;
  localparam int unsigned CoordW      = 10;

  localparam logic [CoordW-1:0] WidthC  = CoordW'(PANEL_WIDTH);
  localparam logic [CoordW-1:0] HeightC = CoordW'(PanelHeight);
  localparam logic [AddrW-1:0]  LastAddr = AddrW'(Depth - 1);

  // Each store word holds every color plane of one pixel: plane p in bits
  // 3p (red), 3p+1 (green), 3p+2 (blue).
  logic [WordW-1:0] mem [Depth];

  logic [1:0]       req_type_q;
  logic [4:0]       xs_q, ys_q;
  logic [5:0]       w_q, h_q;
  logic [63:0]      pat_q;
  logic [WordW-1:0] pen_q;
  logic             ow_q;
  logic [5:0]       walk_column_q, walk_column_d;
  logic [5:0]       walk_row_q, walk_row_d;
  logic [AddrW-1:0] clr_q;
  logic [WordW-1:0] rdata_q;
  rsp_t             rsp_q;

  logic [CoordW-1:0]   xe_c, ye_c, xs_c, ys_c;
  logic [5:0]          fill_w, fill_h, pat_w, pat_h;
  logic [5:0]          w_d, h_d;
  logic [WordW-1:0]    pen_d;
  logic [CoordW-1:0]   px, py;
  logic                in_panel;
  logic [2*CoordW-1:0] addr_full;
  logic [AddrW-1:0]    pix_addr;
  logic                mask_bit;
  logic                col_last, row_last;
  logic                wr_en;
  logic [AddrW-1:0]    wr_addr;
  logic [WordW-1:0]    wr_data;
  rsp_t                rsp_d;

  // Rectangle and pattern extents, clipped at load time
  always_comb begin
    xs_c   = CoordW'(req_i.x_start);
    ys_c   = CoordW'(req_i.y_start);
    xe_c   = (CoordW'(req_i.x_end) > WidthC)  ? WidthC  : CoordW'(req_i.x_end);
    ye_c   = (CoordW'(req_i.y_end) > HeightC) ? HeightC : CoordW'(req_i.y_end);
    fill_w = (xe_c > xs_c) ? 6'(xe_c - xs_c) : 6'd0;
    fill_h = (ye_c > ys_c) ? 6'(ye_c - ys_c) : 6'd0;
    pat_w  = (req_i.pattern_width  > 4'(PatternSide)) ? 6'(PatternSide)
                                                      : 6'(req_i.pattern_width);
    pat_h  = (req_i.pattern_height > 4'(PatternSide)) ? 6'(PatternSide)
                                                      : 6'(req_i.pattern_height);
    case (req_i.req_type)
      REQ_FILL_RECT: begin
        w_d = fill_w;
        h_d = fill_h;
      end
      REQ_PATTERN: begin
        w_d = pat_w;
        h_d = pat_h;
      end
      default: begin
        w_d = 6'd1;
        h_d = 6'd1;
      end
    endcase
    for (int p = 0; p < COLOR_PLANES; p++) begin
      pen_d[3*p]     = req_i.pen_red[7-p];
      pen_d[3*p + 1] = req_i.pen_green[7-p];
      pen_d[3*p + 2] = req_i.pen_blue[7-p];
    end
  end

  // Current pixel of the walk
  always_comb begin
    px        = CoordW'(xs_q) + CoordW'(walk_column_q);
    py        = CoordW'(ys_q) + CoordW'(walk_row_q);
    in_panel  = (px < WidthC) && (py < HeightC);
    addr_full = py * WidthC + px;
    pix_addr  = addr_full[AddrW-1:0];
    mask_bit  = (req_type_q == REQ_PATTERN) ?
                pat_q[{walk_row_q[2:0], ~walk_column_q[2:0]}] : 1'b1;
    col_last  = (walk_column_q == w_q - 6'd1);
    row_last  = (walk_row_q == h_q - 6'd1);
  end

  always_comb begin
    walk_column_d = walk_column_q;
    walk_row_d    = walk_row_q;
    if (cmd_i.load) begin
      walk_column_d = '0;
      walk_row_d    = '0;
    end else if (cmd_i.walk_en) begin
      if (col_last) begin
        walk_column_d = '0;
        walk_row_d    = walk_row_q + 6'd1;
      end else begin
        walk_column_d = walk_column_q + 6'd1;
      end
    end
  end

  assign sts_o.clear_last = (clr_q == LastAddr);
  assign sts_o.walk_last  = col_last && row_last;
  assign sts_o.walk_empty = (w_q == 6'd0) || (h_q == 6'd0);

  // Store write port: clearing pass or walk pixel
  always_comb begin
    if (cmd_i.clear_en) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end else begin
      wr_en   = cmd_i.walk_en && !sts_o.walk_empty && in_panel && (mask_bit || ow_q);
      wr_addr = pix_addr;
      wr_data = mask_bit ? pen_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read_en) begin
      rdata_q <= mem[pix_addr];
    end
  end

  // Rebuild the color from the stored planes; off-panel reads answer black
  always_comb begin
    rsp_d = '0;
    if (req_type_q == REQ_READ_PIXEL) begin
      rsp_d.is_read_reply = 1'b1;
      if (in_panel) begin
        for (int p = 0; p < COLOR_PLANES; p++) begin
          rsp_d.read_red[7-p]   = rdata_q[3*p];
          rsp_d.read_green[7-p] = rdata_q[3*p + 1];
          rsp_d.read_blue[7-p]  = rdata_q[3*p + 2];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_type_q <= req_i.req_type;
      xs_q       <= req_i.x_start;
      ys_q       <= req_i.y_start;
      w_q        <= w_d;
      h_q        <= h_d;
      pat_q      <= req_i.pattern_bits;
      pen_q      <= pen_d;
      ow_q       <= req_i.overwrite_black;
    end
    if (cmd_i.rsp_load) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_column_q <= '0;
      walk_row_q    <= '0;
    end else begin
      walk_column_q <= walk_column_d;
      walk_row_q    <= walk_row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_en) begin
      clr_q <= clr_q + AddrW'(1);
    end else begin
      clr_q <= '0;
    end
  end

  assign rsp_o = rsp_q;

endmodule
`default_nettype wire

// ===== sv/led_bitplane_framebuffer_draw_core.sv =====
// Top level of the bit-plane framebuffer draw engine.
//
//  channel | direction | payload        | handshake
//  --------+-----------+----------------+------------------------
//  in      | input     | lbfd_pkg::req_t | in_valid_i / in_ready_o
//  out     | output    | lbfd_pkg::rsp_t | out_valid_o / out_ready_i
//
// After reset the store is swept to black, one pixel per cycle, covering all
// 2*HALF_HEIGHT*PANEL_WIDTH pixels (1024 by default), with in_ready_o low.
// A drawing command steps through one pixel per cycle of its width*height area
// and writes the drawn pixels through the single store write port; set pixel is
// a one-pixel walk, and read pixel goes through the registered store read.
// One command runs at a time; a finished reply waits in the output register
// while the next command is accepted and started, and the finishing cycle
// stretches while the previous reply is still unaccepted.
`default_nettype none
module led_bitplane_framebuffer_draw_core #(
  parameter int unsigned PANEL_WIDTH  = 32,
  parameter int unsigned HALF_HEIGHT  = 16,
  parameter int unsigned COLOR_PLANES = 2
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  lbfd_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output lbfd_pkg::rsp_t out_rsp_o
);
  import lbfd_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_is_read;

  assign in_is_read = (in_req_i.req_type == REQ_READ_PIXEL);

  lbfd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_is_read_i (in_is_read),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  lbfd_datapath #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .HALF_HEIGHT  (HALF_HEIGHT),
    .COLOR_PLANES (COLOR_PLANES)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (out_rsp_o)
  );

endmodule
`default_nettype wire
